// ===== hw/rtl/ccd_pkg.sv =====
// Cheat code decoder package: shared types, code-kind constants and
// format constants. No dependencies.
`timescale 1ns / 1ps

package ccd_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned NIB_W       = 4;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned STORE_DEPTH = 11;
    localparam int unsigned FIFO_DEPTH  = 2;

    localparam logic [COUNT_W-1:0] MAX_COUNT  = 4'd12;
    localparam logic [COUNT_W-1:0] LEN_GENIE9 = 4'd11;
    localparam logic [COUNT_W-1:0] LEN_GENIE6 = 4'd7;
    localparam logic [COUNT_W-1:0] LEN_SHARK  = 4'd8;
    localparam logic [COUNT_W-1:0] DASH_POS_A = 4'd3;
    localparam logic [COUNT_W-1:0] DASH_POS_B = 4'd7;

    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2d;
    localparam logic [15:0]       ADDR_INV   = 16'hf000;
    localparam logic [7:0]        CMP_XOR    = 8'hba;

    localparam logic [1:0] KIND_GENIE9 = 2'd0;
    localparam logic [1:0] KIND_GENIE6 = 2'd1;
    localparam logic [1:0] KIND_SHARK  = 2'd2;

    // One classified character as it sits in the queue
    typedef struct packed {
        logic [NIB_W-1:0] nibble;
        logic             hex;
        logic             dash;
        logic             last;
    } t_char_class;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  code_kind;
        logic [15:0] target_address;
        logic [7:0]  new_value;
        logic [7:0]  compare_value;
        logic [7:0]  bank_byte;
    } t_result;

endpackage

// ===== hw/rtl/cheat_code_decoder_top.sv =====
// Path: the last character passes through the queue and then the result register before its result appears.
// Throughput: one character per cycle while the queue is not full; the back end retires one queued
// character per cycle, and a final character waits only on a held result.
// Reset: synchronous, active low; clears the queue, the position counter,
// the form flags and the output valid. Digit nibbles are not reset.
`timescale 1ns / 1ps

module cheat_code_decoder_top #(
    parameter int unsigned FIFO_DEPTH = ccd_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] target_address, [23:16] new_value,
                                        // [31:24] compare_value, [39:32] bank_byte
    output logic [2:0]  m_axis_tuser    // [0] valid_res, [2:1] code_kind
);

    ccd_pkg::t_char_class w_class;
    ccd_pkg::t_char_class w_head;
    ccd_pkg::t_fifo_stat  w_stat;
    ccd_pkg::t_result     w_result;
    logic                 w_push;
    logic                 w_pop;

    ccd_front u_front (
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_stat  (w_stat),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_class (w_class)
    );

    ccd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_class),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_stat  (w_stat)
    );

    ccd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {w_result.bank_byte, w_result.compare_value,
                           w_result.new_value, w_result.target_address};
    assign m_axis_tuser = {w_result.code_kind, w_result.valid_res};

    // A final character must not overwrite a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_head.last && m_axis_tvalid && !m_axis_tready))
        else $error("result overwritten while stalled");

    // A new result comes only from retiring a final character
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_pop && w_head.last))
        else $error("result without final character");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/ccd_front.sv =====
// Cheat code decoder front end: takes the input stream and classifies each
// character (hex digit value, dash). Depends on ccd_pkg.
`timescale 1ns / 1ps

module ccd_front (
    input  logic                  i_valid,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    input  ccd_pkg::t_fifo_stat   i_stat,
    output logic                  o_ready,
    output logic                  o_push,
    output ccd_pkg::t_char_class  o_class
);

    logic w_num;
    logic w_lower;
    logic w_upper;

    always_comb begin
        w_num   = (i_char >= 8'h30) && (i_char <= 8'h39);
        w_lower = (i_char >= 8'h61) && (i_char <= 8'h66);
        w_upper = (i_char >= 8'h41) && (i_char <= 8'h46);

        o_class.hex  = w_num || w_lower || w_upper;
        o_class.dash = (i_char == ccd_pkg::CHAR_DASH);
        o_class.last = i_last;
        // 'a'/'A' low nibbles are 1, so value = low nibble + 9
        if (w_num) begin
            o_class.nibble = i_char[3:0];
        end else if (w_lower || w_upper) begin
            o_class.nibble = i_char[3:0] + 4'd9;
        end else begin
            o_class.nibble = '0;
        end
    end

    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && !i_stat.full;

endmodule

// ===== hw/rtl/ccd_fifo.sv =====
// Cheat code decoder queue: short FIFO of classified characters between
// the front end and the decode back end. Depends on ccd_pkg.
`timescale 1ns / 1ps

module ccd_fifo #(
    parameter int unsigned DEPTH = ccd_pkg::FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ccd_pkg::t_char_class  i_data,
    input  logic                  i_pop,
    output ccd_pkg::t_char_class  o_data,
    output ccd_pkg::t_fifo_stat   o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ccd_pkg::t_char_class r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);

endmodule

// ===== hw/rtl/ccd_back.sv =====
// Cheat code decoder back end: tracks position and form checks, keeps
// the digit nibbles and builds the result register. Depends on ccd_pkg.
`timescale 1ns / 1ps

module ccd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccd_pkg::t_char_class  i_head,
    input  ccd_pkg::t_fifo_stat   i_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ccd_pkg::t_result      o_result
);

    localparam int unsigned DEPTH = ccd_pkg::STORE_DEPTH;

    logic [ccd_pkg::COUNT_W-1:0] r_count;
    logic [ccd_pkg::COUNT_W-1:0] n_count;
    logic                        r_dashed_ok;
    logic                        n_dashed_ok;
    logic                        r_plain_ok;
    logic                        n_plain_ok;
    logic [ccd_pkg::NIB_W-1:0]   r_digit [DEPTH];
    logic [ccd_pkg::NIB_W-1:0]   n_digit [DEPTH];
    logic                        r_out_valid;
    ccd_pkg::t_result            r_result;
    ccd_pkg::t_result            n_result;
    logic [ccd_pkg::COUNT_W-1:0] w_len;
    logic                        w_out_free;
    logic [7:0]                  w_raw_cmp;

    assign w_out_free = !r_out_valid || i_ready;
    // A non-final character never needs the output register
    assign o_pop = !i_stat.empty && (!i_head.last || w_out_free);

    always_comb begin
        n_dashed_ok = r_dashed_ok;
        n_plain_ok  = r_plain_ok;
        for (int i = 0; i < DEPTH; i++) begin
            n_digit[i] = r_digit[i];
            if (r_count == ccd_pkg::COUNT_W'(i)) begin
                n_digit[i] = i_head.nibble;
            end
        end
        if (r_count < ccd_pkg::COUNT_W'(DEPTH)) begin
            if (r_count == ccd_pkg::DASH_POS_A || r_count == ccd_pkg::DASH_POS_B) begin
                if (!i_head.dash) n_dashed_ok = 1'b0;
            end else if (!i_head.hex) begin
                n_dashed_ok = 1'b0;
            end
            if (r_count < ccd_pkg::LEN_SHARK && !i_head.hex) n_plain_ok = 1'b0;
        end
        w_len   = (r_count == ccd_pkg::MAX_COUNT) ? ccd_pkg::MAX_COUNT : r_count + 1'b1;
        n_count = w_len;

        w_raw_cmp = {n_digit[8], n_digit[10]};
        n_result  = '0;
        if ((w_len == ccd_pkg::LEN_GENIE9 || w_len == ccd_pkg::LEN_GENIE6) && n_dashed_ok) begin
            n_result.valid_res      = 1'b1;
            n_result.code_kind      = (w_len == ccd_pkg::LEN_GENIE9) ?
                                      ccd_pkg::KIND_GENIE9 : ccd_pkg::KIND_GENIE6;
            n_result.new_value      = {n_digit[0], n_digit[1]};
            n_result.target_address = {n_digit[6], n_digit[2], n_digit[4], n_digit[5]}
                                      ^ ccd_pkg::ADDR_INV;
            if (w_len == ccd_pkg::LEN_GENIE9) begin
                n_result.compare_value = {w_raw_cmp[1:0], w_raw_cmp[7:2]} ^ ccd_pkg::CMP_XOR;
            end
        end else if (w_len == ccd_pkg::LEN_SHARK && n_plain_ok) begin
            n_result.valid_res      = 1'b1;
            n_result.code_kind      = ccd_pkg::KIND_SHARK;
            n_result.bank_byte      = {n_digit[0], n_digit[1]};
            n_result.new_value      = {n_digit[2], n_digit[3]};
            n_result.target_address = {n_digit[6], n_digit[7], n_digit[4], n_digit[5]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dashed_ok <= 1'b1;
            r_plain_ok  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_head.last) begin
                    r_count     <= '0;
                    r_dashed_ok <= 1'b1;
                    r_plain_ok  <= 1'b1;
                end else begin
                    r_count     <= n_count;
                    r_dashed_ok <= n_dashed_ok;
                    r_plain_ok  <= n_plain_ok;
                end
            end
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_digit[i] <= n_digit[i];
            end
            if (i_head.last) begin
                r_result <= n_result;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule
